>>> rtl/core/scpc_pkg.sv
// ============================================================================
// scpc_pkg
// Shared types, register indexes and helpers for the SYNC cycle block.
// ============================================================================
`timescale 1ns / 1ps

package scpc_pkg;

    localparam int TIME_W  = 16;
    localparam int COUNT_W = 16;
    localparam int AUX_W   = 8;
    localparam int MASK_W  = 16;
    localparam int INDEX_W = 3;
    localparam int DATA_W  = 16;

    // Auxiliary counter values from this limit upwards give an empty mask
    localparam int AUX_MASK_WIDTH = 16;
    localparam logic [AUX_W-1:0] AUX_LIMIT =
        AUX_W'((AUX_MASK_WIDTH < MASK_W) ? AUX_MASK_WIDTH : MASK_W);
    localparam logic [MASK_W-1:0] MASK_ONE = 16'h0001;

    // Configuration register indexes
    localparam logic [INDEX_W-1:0] REG_SYNC_ENABLE    = 3'd0;
    localparam logic [INDEX_W-1:0] REG_PRODUCER_MODE  = 3'd1;
    localparam logic [INDEX_W-1:0] REG_CYCLE_PERIOD   = 3'd2;
    localparam logic [INDEX_W-1:0] REG_WINDOW_LENGTH  = 3'd3;
    localparam logic [INDEX_W-1:0] REG_MAX_SYNC_COUNT = 3'd4;
    localparam logic [INDEX_W-1:0] REG_MAX_AUX_COUNT  = 3'd5;

    typedef struct packed {
        logic                sync_enable;
        logic                producer_mode;
        logic [TIME_W-1:0]   sync_period;
        logic [TIME_W-1:0]   window_span;
        logic [COUNT_W-1:0]  max_sync_count;
        logic [AUX_W-1:0]    max_aux_count;
    } cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0]   elapsed_ms;
        logic                rx_valid;
        logic [COUNT_W-1:0]  rx_sync_count;
        logic [AUX_W-1:0]    rx_aux_count;
    } tick_t;

    typedef struct packed {
        logic                sync_event;
        logic                tx_request;
        logic [COUNT_W-1:0]  tx_sync_count;
        logic [AUX_W-1:0]    tx_aux_count;
        logic                inside_window;
        logic [MASK_W-1:0]   aux_onehot;
    } result_t;

    function automatic logic [MASK_W-1:0] aux_mask_of(input logic [AUX_W-1:0] aux);
        logic [MASK_W-1:0] mask;
        mask = '0;
        if (aux < AUX_LIMIT)
        begin
            mask = MASK_ONE << aux[$clog2(MASK_W)-1:0];
        end
        return mask;
    endfunction

endpackage

>>> rtl/core/scpc_if.sv
// ============================================================================
// scpc_tick_if / scpc_result_if
// Valid/ready channels for tick transactions and result transactions.
// ============================================================================
`timescale 1ns / 1ps

interface scpc_tick_if;
    logic                         valid;
    logic                         ready;
    logic [scpc_pkg::TIME_W-1:0]  elapsed_ms;
    logic                         rx_valid;
    logic [scpc_pkg::COUNT_W-1:0] rx_sync_count;
    logic [scpc_pkg::AUX_W-1:0]   rx_aux_count;

    modport source (output valid, elapsed_ms, rx_valid, rx_sync_count, rx_aux_count,
                    input ready);
    modport sink   (input valid, elapsed_ms, rx_valid, rx_sync_count, rx_aux_count,
                    output ready);
endinterface

interface scpc_result_if;
    logic                         valid;
    logic                         ready;
    logic                         sync_event;
    logic                         tx_request;
    logic [scpc_pkg::COUNT_W-1:0] tx_sync_count;
    logic [scpc_pkg::AUX_W-1:0]   tx_aux_count;
    logic                         inside_window;
    logic [scpc_pkg::MASK_W-1:0]  aux_onehot;

    modport source (output valid, sync_event, tx_request, tx_sync_count, tx_aux_count,
                    inside_window, aux_onehot, input ready);
    modport sink   (input valid, sync_event, tx_request, tx_sync_count, tx_aux_count,
                    inside_window, aux_onehot, output ready);
endinterface

>>> rtl/core/scpc_cfg.sv
// ============================================================================
// scpc_cfg
// Configuration register bank, written through a plain indexed write port.
// ============================================================================
`timescale 1ns / 1ps

module scpc_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [scpc_pkg::INDEX_W-1:0]  cfg_index,
    input  logic [scpc_pkg::DATA_W-1:0]   cfg_data,
    output scpc_pkg::cfg_t                cfg
);
    import scpc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SYNC_ENABLE:    cfg_next.sync_enable    = cfg_data[0];
                REG_PRODUCER_MODE:  cfg_next.producer_mode  = cfg_data[0];
                REG_CYCLE_PERIOD:   cfg_next.sync_period    = cfg_data[TIME_W-1:0];
                REG_WINDOW_LENGTH:  cfg_next.window_span    = cfg_data[TIME_W-1:0];
                REG_MAX_SYNC_COUNT: cfg_next.max_sync_count = cfg_data[COUNT_W-1:0];
                REG_MAX_AUX_COUNT:  cfg_next.max_aux_count  = cfg_data[AUX_W-1:0];
                default:            cfg_next = cfg_reg;  // drop unknown indexes
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/core/scpc_engine.sv
// ============================================================================
// scpc_engine
// Cycle timer, sync and auxiliary counters, window flag and one-hot mask.
// ============================================================================
`timescale 1ns / 1ps

module scpc_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  scpc_pkg::cfg_t    cfg,
    input  scpc_pkg::tick_t   item,
    output scpc_pkg::result_t res
);
    import scpc_pkg::*;

    logic [TIME_W-1:0]  ct_reg,   ct_next;
    logic [COUNT_W-1:0] sc_reg,   sc_next;
    logic [AUX_W-1:0]   ac_reg,   ac_next;
    logic [MASK_W-1:0]  mask_reg, mask_next;
    logic               win_reg,  win_next;

    logic [TIME_W-1:0]  sum;
    logic [TIME_W-1:0]  ct_acc;
    logic [COUNT_W-1:0] sc_inc;
    logic [AUX_W-1:0]   ac_inc;
    logic [AUX_W-1:0]   ac_wrap;

    always_comb
    begin
        sum     = ct_reg + item.elapsed_ms;
        ct_acc  = (sum > ct_reg) ? sum : ct_reg;   // hold on a wrapping add
        sc_inc  = sc_reg + COUNT_W'(1);
        ac_inc  = ac_reg + AUX_W'(1);
        ac_wrap = (ac_inc > cfg.max_aux_count) ? '0 : ac_inc;

        ct_next   = ct_reg;
        sc_next   = sc_reg;
        ac_next   = ac_reg;
        mask_next = mask_reg;
        win_next  = win_reg;
        res       = '0;

        if (cfg.sync_enable)
        begin
            ct_next = ct_acc;
            if (cfg.producer_mode)
            begin
                if (ct_acc >= cfg.sync_period)
                begin
                    if (sc_inc > cfg.max_sync_count)
                    begin
                        sc_next   = COUNT_W'(1);
                        ac_next   = ac_wrap;
                        mask_next = aux_mask_of(ac_wrap);
                    end
                    else
                    begin
                        sc_next = sc_inc;
                    end
                    res.tx_request    = 1'b1;
                    res.tx_sync_count = sc_next;
                    res.tx_aux_count  = ac_next;
                    res.sync_event    = 1'b1;
                    ct_next           = '0;
                end
            end
            else if (item.rx_valid)
            begin
                sc_next        = item.rx_sync_count;
                ac_next        = item.rx_aux_count;
                mask_next      = aux_mask_of(item.rx_aux_count);
                ct_next        = '0;
                res.sync_event = 1'b1;
            end
            win_next = (ct_next <= cfg.window_span);
        end

        res.inside_window = win_next;
        res.aux_onehot    = mask_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ct_reg   <= '0;
            sc_reg   <= '0;
            ac_reg   <= '0;
            mask_reg <= '0;
            win_reg  <= 1'b0;
        end
        else if (step)
        begin
            ct_reg   <= ct_next;
            sc_reg   <= sc_next;
            ac_reg   <= ac_next;
            mask_reg <= mask_next;
            win_reg  <= win_next;
        end
    end

endmodule

>>> rtl/core/sync_cycle_producer_consumer.sv
// ============================================================================
// sync_cycle_producer_consumer
// SYNC cycle producer / consumer. Each tick transaction carries the elapsed
// milliseconds and, optionally, a received SYNC frame's counters; each tick
// yields exactly one result transaction. A tick is held in an input register,
// where the timer, counter and window logic updates the state and forms the
// result, which is then held in an output register until taken. A new tick
// is accepted every clock cycle while results are taken, so the sustained
// rate is one tick per cycle; the result is registered in the output register
// as the tick moves on from the input register. In producer mode a timer at or
// past the period emits a SYNC with the incremented counter (past the maximum
// it wraps to 1 and the auxiliary counter steps); in consumer mode a received
// frame loads the counters. Write the configuration only while no tick is in flight.
// ============================================================================
`timescale 1ns / 1ps

module sync_cycle_producer_consumer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [scpc_pkg::INDEX_W-1:0]  cfg_index,
    input  logic [scpc_pkg::DATA_W-1:0]   cfg_data,
    scpc_tick_if.sink                     tick,
    scpc_result_if.source                 result
);
    import scpc_pkg::*;

    cfg_t    cfg;
    tick_t   tick_in;
    tick_t   item_reg;
    logic    item_valid_reg;
    result_t res_comb;
    result_t res_reg;
    logic    res_valid_reg;
    logic    advance;
    logic    step;

    // Advance the whole pipe whenever the output register is free or drains
    assign advance = !res_valid_reg || result.ready;
    assign step    = item_valid_reg && advance;

    // Take a new tick while the input register is empty or moving on
    assign tick.ready = !item_valid_reg || advance;

    assign tick_in.elapsed_ms    = tick.elapsed_ms;
    assign tick_in.rx_valid      = tick.rx_valid;
    assign tick_in.rx_sync_count = tick.rx_sync_count;
    assign tick_in.rx_aux_count  = tick.rx_aux_count;

    scpc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    scpc_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .cfg   (cfg),
        .item  (item_reg),
        .res   (res_comb)
    );

    // Input register: hold the accepted tick for the update cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (tick.ready)
        begin
            item_valid_reg <= tick.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
        begin
            item_reg <= tick_in;
        end
    end

    // Output register: hold the result until the sink takes the transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res_comb;
        end
    end

    assign result.valid         = res_valid_reg;
    assign result.sync_event    = res_reg.sync_event;
    assign result.tx_request    = res_reg.tx_request;
    assign result.tx_sync_count = res_reg.tx_sync_count;
    assign result.tx_aux_count  = res_reg.tx_aux_count;
    assign result.inside_window = res_reg.inside_window;
    assign result.aux_onehot    = res_reg.aux_onehot;

`ifndef SYNTHESIS
    // A transmitted frame is always a SYNC event
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.tx_request |-> res_reg.sync_event)
        else $error("tx_request without sync_event");

    // Frame counters are zero when nothing is transmitted
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_reg.tx_request |->
            (res_reg.tx_sync_count == '0) && (res_reg.tx_aux_count == '0))
        else $error("frame counters set without tx_request");

    // The auxiliary mask never has more than one bit set
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> $onehot0(res_reg.aux_onehot))
        else $error("aux mask not one-hot");

    // A tick stalled in the input register stays there
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && !advance |=> item_valid_reg && $stable(item_reg))
        else $error("stalled tick lost");
`endif

endmodule
